// File: rtl/srarq_pkg.sv
// Shared types, constants and helpers for the selective-repeat ARQ window unit.
`default_nettype none

package srarq_pkg;

  localparam int SEQ_MAX       = 31;
  localparam int WINDOW        = 16;
  localparam int SEQ_MOD       = SEQ_MAX + 1;
  localparam int SEQ_W         = $clog2(SEQ_MOD);
  localparam int SLOT_W        = $clog2(WINDOW);
  localparam int STOP_W        = $clog2(WINDOW + 1);
  localparam int OUT_MAX       = 31;
  localparam int OUT_W         = $clog2(OUT_MAX + 1);
  localparam int LEN_W         = 10;
  localparam int MIN_FRAME_LEN = 5;
  localparam int HDR_LEN       = 7;

  typedef logic [SEQ_W-1:0]  seq_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [STOP_W-1:0] stop_t;
  typedef logic [OUT_W-1:0]  cnt_t;
  typedef logic [LEN_W-1:0]  len_t;

  // Event codes
  localparam logic [2:0] ACT_NET_READY    = 3'd0;
  localparam logic [2:0] ACT_PHY_READY    = 3'd1;
  localparam logic [2:0] ACT_FRAME_RX     = 3'd2;
  localparam logic [2:0] ACT_ACK_TIMEOUT  = 3'd3;
  localparam logic [2:0] ACT_DATA_TIMEOUT = 3'd4;

  // Received frame kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_NAK  = 2'd2;

  // Command codes of a result word
  localparam logic [2:0] CMD_SEND_DATA  = 3'd0;
  localparam logic [2:0] CMD_SEND_ACK   = 3'd1;
  localparam logic [2:0] CMD_SEND_NAK   = 3'd2;
  localparam logic [2:0] CMD_ACK_TIMER  = 3'd3;
  localparam logic [2:0] CMD_STORE      = 3'd4;
  localparam logic [2:0] CMD_DELIVER    = 3'd5;
  localparam logic [2:0] CMD_STOP_TIMER = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SEND_NEW,
    ST_SEND_ACK,
    ST_RESEND,
    ST_BAD_NAK,
    ST_DATA_HEAD,
    ST_STORE,
    ST_DELIVER,
    ST_ACK_TIMER,
    ST_NAK_RESEND,
    ST_ACK_LOOP,
    ST_STATUS
  } st_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_SEND_NEW,
    OP_PHY_UP,
    OP_SEND_ACK,
    OP_RESEND,
    OP_NAK,
    OP_ACK_TIMER,
    OP_STORE,
    OP_DELIVER,
    OP_NAK_RESEND,
    OP_ACK_STEP,
    OP_STATUS
  } op_e;

  typedef struct packed {
    logic [2:0] action;
    logic       crc_good;
    len_t       frame_len;
    logic [1:0] frame_kind;
    seq_t       frame_seq;
    seq_t       ack_in;
    slot_t      timeout_slot;
  } item_t;

  typedef struct packed {
    logic [2:0] command;
    logic       is_status;
    seq_t       seq_out;
    seq_t       ack_out;
    slot_t      slot_out;
    len_t       deliver_len;
    logic       network_enable;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [2:0] action;
    logic       bad_frame;
    logic       data_frame;
    logic       nak_frame;
    logic       nak_allowed;
    logic       nak_first;
    logic       data_accept;
    logic       arrived_low;
    logic       any_delivered;
    logic       resend_ok;
    logic       ack_pending;
    logic       out_free;
  } dp_sts_t;

  // True when b lies in the circular window [a, c)
  function automatic logic in_window(seq_t a, seq_t b, seq_t c);
    return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
  endfunction

endpackage

`default_nettype wire

// File: rtl/srarq_in_if.sv
// Event channel: valid/ready handshake carrying one event word.
`default_nettype none

interface srarq_in_if import srarq_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic       crc_good;
  len_t       frame_len;
  logic [1:0] frame_kind;
  seq_t       frame_seq;
  seq_t       ack_in;
  slot_t      timeout_slot;

  modport source (
    output valid, action, crc_good, frame_len, frame_kind, frame_seq, ack_in,
           timeout_slot,
    input  ready
  );
  modport sink (
    input  valid, action, crc_good, frame_len, frame_kind, frame_seq, ack_in,
           timeout_slot,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/srarq_out_if.sv
// Result channel: valid/ready handshake carrying one command or status word.
`default_nettype none

interface srarq_out_if import srarq_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic       is_status;
  seq_t       seq_out;
  seq_t       ack_out;
  slot_t      slot_out;
  len_t       deliver_len;
  logic       network_enable;
  logic       last;

  modport source (
    output valid, command, is_status, seq_out, ack_out, slot_out, deliver_len,
           network_enable, last,
    input  ready
  );
  modport sink (
    input  valid, command, is_status, seq_out, ack_out, slot_out, deliver_len,
           network_enable, last,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/selective_repeat_arq_window_unit.sv
// Top level of the selective-repeat ARQ window unit: controller plus datapath.
`default_nettype none

// Selective-repeat ARQ window control. Each event word (network ready, phy
// ready, frame received, ack timeout, data timeout) is turned into a burst
// of command words on the result channel, closed by one status word with
// is_status and last set and network_enable valid. The unit takes one event
// at a time: it accepts and decodes it, then issues its result words in
// turn, with an idle step per acknowledged sequence number beyond the
// sixteenth timer stop, a step to end an in-order delivery scan and a step
// to leave the acknowledge scan of a good frame; a stalled result channel
// holds the sequence. The longest event is a data frame that releases a
// full window of deliveries and acknowledges 31 frames. A result word sits
// in an output register, so the next event is accepted while the closing
// status word still waits to be taken. Sequence numbers run modulo 32 and
// receive slots are sequence numbers modulo 16; the unit holds no payload,
// CRC or timers and only commands them.

module selective_repeat_arq_window_unit import srarq_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  srarq_in_if.sink    in_i,
  srarq_out_if.source out_o
);

  item_t   item;
  res_t    res;
  dp_sts_t sts;
  op_e     op;
  logic    out_valid;

  // Pack the event word for the datapath latch
  assign item.action       = in_i.action;
  assign item.crc_good     = in_i.crc_good;
  assign item.frame_len    = in_i.frame_len;
  assign item.frame_kind   = in_i.frame_kind;
  assign item.frame_seq    = in_i.frame_seq;
  assign item.ack_in       = in_i.ack_in;
  assign item.timeout_slot = in_i.timeout_slot;

  srarq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .sts_i      (sts),
    .in_ready_o (in_i.ready),
    .op_o       (op)
  );

  srarq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .item_i      (item),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .res_o       (res),
    .sts_o       (sts)
  );

  // Drive the result channel straight from the output register
  assign out_o.valid          = out_valid;
  assign out_o.command        = res.command;
  assign out_o.is_status      = res.is_status;
  assign out_o.seq_out        = res.seq_out;
  assign out_o.ack_out        = res.ack_out;
  assign out_o.slot_out       = res.slot_out;
  assign out_o.deliver_len    = res.deliver_len;
  assign out_o.network_enable = res.network_enable;
  assign out_o.last           = res.last;

endmodule

`default_nettype wire

// File: rtl/srarq_dp.sv
// Datapath: window state, arrived bitmap, latched event and output register.
`default_nettype none

module srarq_dp import srarq_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire op_e     op_i,
  input  wire item_t   item_i,
  input  wire logic    out_ready_i,
  output logic         out_valid_o,
  output res_t         res_o,
  output dp_sts_t      sts_o
);

  item_t              item_q, item_d;
  seq_t               send_next_q, send_next_d;
  seq_t               ack_wanted_q, ack_wanted_d;
  seq_t               recv_low_q, recv_low_d;
  seq_t               recv_high_q, recv_high_d;
  cnt_t               outstanding_q, outstanding_d;
  logic               phy_idle_q, phy_idle_d;
  logic               nak_allowed_q, nak_allowed_d;
  logic [WINDOW-1:0]  arrived_q, arrived_d;
  stop_t              stops_q, stops_d;
  logic               any_q, any_d;
  logic               out_valid_q, out_valid_d;
  res_t               res_q, res_d;

  seq_t  ack_no;
  slot_t rx_slot;
  slot_t low_slot;
  seq_t  nak_next;
  seq_t  resend_seq;
  len_t  dlen;
  logic  out_free;

  assign ack_no   = recv_low_q + seq_t'(SEQ_MAX);
  assign rx_slot  = item_q.frame_seq[SLOT_W-1:0];
  assign low_slot = recv_low_q[SLOT_W-1:0];
  assign nak_next = item_q.ack_in + seq_t'(1);
  assign dlen     = (item_q.frame_len > len_t'(HDR_LEN)) ?
                    item_q.frame_len - len_t'(HDR_LEN) : '0;
  assign out_free = !out_valid_q || out_ready_i;

  // Data timer slot outside the send window moves up one window
  always_comb begin
    resend_seq = seq_t'(item_q.timeout_slot);
    if (!in_window(ack_wanted_q, resend_seq, send_next_q)) begin
      resend_seq = resend_seq + seq_t'(WINDOW);
    end
  end

  always_comb begin
    sts_o.action        = item_q.action;
    sts_o.bad_frame     = (item_q.frame_len < len_t'(MIN_FRAME_LEN)) || !item_q.crc_good;
    sts_o.data_frame    = (item_q.frame_kind == KIND_DATA);
    sts_o.nak_frame     = (item_q.frame_kind == KIND_NAK);
    sts_o.nak_allowed   = nak_allowed_q;
    sts_o.nak_first     = (item_q.frame_seq != recv_low_q) && nak_allowed_q;
    sts_o.data_accept   = in_window(recv_low_q, item_q.frame_seq, recv_high_q) &&
                          !arrived_q[rx_slot];
    sts_o.arrived_low   = arrived_q[low_slot];
    sts_o.any_delivered = any_q;
    sts_o.resend_ok     = in_window(ack_wanted_q, nak_next, send_next_q);
    sts_o.ack_pending   = in_window(ack_wanted_q, item_q.ack_in, send_next_q);
    sts_o.out_free      = out_free;
  end

  always_comb begin
    item_d        = item_q;
    send_next_d   = send_next_q;
    ack_wanted_d  = ack_wanted_q;
    recv_low_d    = recv_low_q;
    recv_high_d   = recv_high_q;
    outstanding_d = outstanding_q;
    phy_idle_d    = phy_idle_q;
    nak_allowed_d = nak_allowed_q;
    arrived_d     = arrived_q;
    stops_d       = stops_q;
    any_d         = any_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    res_d         = res_q;

    unique case (op_i)
      OP_NONE: begin
      end
      OP_LATCH: begin
        item_d  = item_i;
        stops_d = '0;
        any_d   = 1'b0;
      end
      OP_SEND_NEW: begin
        if (outstanding_q != cnt_t'(OUT_MAX)) begin
          outstanding_d = outstanding_q + cnt_t'(1);
        end
        phy_idle_d        = 1'b0;
        send_next_d       = send_next_q + seq_t'(1);
        out_valid_d       = 1'b1;
        res_d             = '0;
        res_d.command     = CMD_SEND_DATA;
        res_d.seq_out     = send_next_q;
        res_d.ack_out     = ack_no;
        res_d.slot_out    = send_next_q[SLOT_W-1:0];
      end
      OP_PHY_UP: begin
        phy_idle_d = 1'b1;
      end
      OP_SEND_ACK: begin
        phy_idle_d    = 1'b0;
        out_valid_d   = 1'b1;
        res_d         = '0;
        res_d.command = CMD_SEND_ACK;
        res_d.ack_out = ack_no;
      end
      OP_RESEND: begin
        phy_idle_d     = 1'b0;
        out_valid_d    = 1'b1;
        res_d          = '0;
        res_d.command  = CMD_SEND_DATA;
        res_d.seq_out  = resend_seq;
        res_d.ack_out  = ack_no;
        res_d.slot_out = resend_seq[SLOT_W-1:0];
      end
      OP_NAK: begin
        nak_allowed_d = 1'b0;
        phy_idle_d    = 1'b0;
        out_valid_d   = 1'b1;
        res_d         = '0;
        res_d.command = CMD_SEND_NAK;
        res_d.ack_out = ack_no;
      end
      OP_ACK_TIMER: begin
        out_valid_d   = 1'b1;
        res_d         = '0;
        res_d.command = CMD_ACK_TIMER;
      end
      OP_STORE: begin
        arrived_d[rx_slot] = 1'b1;
        out_valid_d        = 1'b1;
        res_d              = '0;
        res_d.command      = CMD_STORE;
        res_d.seq_out      = item_q.frame_seq;
        res_d.slot_out     = rx_slot;
      end
      OP_DELIVER: begin
        arrived_d[low_slot] = 1'b0;
        nak_allowed_d       = 1'b1;
        recv_low_d          = recv_low_q + seq_t'(1);
        recv_high_d         = recv_high_q + seq_t'(1);
        any_d               = 1'b1;
        out_valid_d         = 1'b1;
        res_d               = '0;
        res_d.command       = CMD_DELIVER;
        res_d.seq_out       = recv_low_q;
        res_d.slot_out      = low_slot;
        res_d.deliver_len   = dlen;
      end
      OP_NAK_RESEND: begin
        phy_idle_d     = 1'b0;
        out_valid_d    = 1'b1;
        res_d          = '0;
        res_d.command  = CMD_SEND_DATA;
        res_d.seq_out  = nak_next;
        res_d.ack_out  = ack_no;
        res_d.slot_out = nak_next[SLOT_W-1:0];
      end
      OP_ACK_STEP: begin
        // Only the first window's worth of acks issues a timer stop
        if (stops_q < stop_t'(WINDOW)) begin
          stops_d        = stops_q + stop_t'(1);
          out_valid_d    = 1'b1;
          res_d          = '0;
          res_d.command  = CMD_STOP_TIMER;
          res_d.slot_out = ack_wanted_q[SLOT_W-1:0];
        end
        if (outstanding_q != '0) begin
          outstanding_d = outstanding_q - cnt_t'(1);
        end
        ack_wanted_d = ack_wanted_q + seq_t'(1);
      end
      OP_STATUS: begin
        out_valid_d          = 1'b1;
        res_d                = '0;
        res_d.command        = CMD_SEND_DATA;
        res_d.is_status      = 1'b1;
        res_d.network_enable = (outstanding_q < cnt_t'(WINDOW)) && phy_idle_q;
        res_d.last           = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      send_next_q   <= '0;
      ack_wanted_q  <= '0;
      recv_low_q    <= '0;
      recv_high_q   <= seq_t'(WINDOW % SEQ_MOD);
      outstanding_q <= '0;
      phy_idle_q    <= 1'b0;
      nak_allowed_q <= 1'b1;
      arrived_q     <= '0;
      stops_q       <= '0;
      any_q         <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      send_next_q   <= send_next_d;
      ack_wanted_q  <= ack_wanted_d;
      recv_low_q    <= recv_low_d;
      recv_high_q   <= recv_high_d;
      outstanding_q <= outstanding_d;
      phy_idle_q    <= phy_idle_d;
      nak_allowed_q <= nak_allowed_d;
      arrived_q     <= arrived_d;
      stops_q       <= stops_d;
      any_q         <= any_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  // Receive window always spans exactly one window
  a_rx_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (recv_high_q - recv_low_q) == seq_t'(WINDOW))
    else $error("receive window span broken");

  a_stop_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stops_q <= stop_t'(WINDOW))
    else $error("timer stop count past window");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.is_status == res_q.last))
    else $error("status word and last flag disagree");

endmodule

`default_nettype wire

// File: rtl/srarq_ctrl.sv
// Controller: sequences one event into its command words and closing status.
`default_nettype none

module srarq_ctrl import srarq_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  input  wire dp_sts_t sts_i,
  output logic         in_ready_o,
  output op_e          op_o
);

  st_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (sts_i.action)
          ACT_NET_READY:    state_d = ST_SEND_NEW;
          ACT_ACK_TIMEOUT:  state_d = ST_SEND_ACK;
          ACT_DATA_TIMEOUT: state_d = ST_RESEND;
          ACT_FRAME_RX: begin
            if (sts_i.bad_frame) begin
              state_d = sts_i.nak_allowed ? ST_BAD_NAK : ST_STATUS;
            end else if (sts_i.data_frame) begin
              state_d = ST_DATA_HEAD;
            end else if (sts_i.nak_frame && sts_i.resend_ok) begin
              state_d = ST_NAK_RESEND;
            end else begin
              state_d = ST_ACK_LOOP;
            end
          end
          default:          state_d = ST_STATUS;
        endcase
      end
      ST_SEND_NEW, ST_SEND_ACK, ST_RESEND, ST_BAD_NAK: begin
        if (sts_i.out_free) state_d = ST_STATUS;
      end
      ST_DATA_HEAD: begin
        if (sts_i.out_free) state_d = sts_i.data_accept ? ST_STORE : ST_ACK_LOOP;
      end
      ST_STORE: begin
        if (sts_i.out_free) state_d = ST_DELIVER;
      end
      ST_DELIVER: begin
        if (!sts_i.arrived_low) begin
          state_d = sts_i.any_delivered ? ST_ACK_TIMER : ST_ACK_LOOP;
        end
      end
      ST_ACK_TIMER, ST_NAK_RESEND: begin
        if (sts_i.out_free) state_d = ST_ACK_LOOP;
      end
      ST_ACK_LOOP: begin
        if (!sts_i.ack_pending) state_d = ST_STATUS;
      end
      ST_STATUS: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    op_o       = OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) op_o = OP_LATCH;
      end
      ST_DECODE: begin
        if (sts_i.action == ACT_PHY_READY) op_o = OP_PHY_UP;
      end
      ST_SEND_NEW:   if (sts_i.out_free) op_o = OP_SEND_NEW;
      ST_SEND_ACK:   if (sts_i.out_free) op_o = OP_SEND_ACK;
      ST_RESEND:     if (sts_i.out_free) op_o = OP_RESEND;
      ST_BAD_NAK:    if (sts_i.out_free) op_o = OP_NAK;
      ST_DATA_HEAD: begin
        if (sts_i.out_free) op_o = sts_i.nak_first ? OP_NAK : OP_ACK_TIMER;
      end
      ST_STORE:      if (sts_i.out_free) op_o = OP_STORE;
      ST_DELIVER:    if (sts_i.out_free && sts_i.arrived_low) op_o = OP_DELIVER;
      ST_ACK_TIMER:  if (sts_i.out_free) op_o = OP_ACK_TIMER;
      ST_NAK_RESEND: if (sts_i.out_free) op_o = OP_NAK_RESEND;
      ST_ACK_LOOP:   if (sts_i.out_free && sts_i.ack_pending) op_o = OP_ACK_STEP;
      ST_STATUS:     if (sts_i.out_free) op_o = OP_STATUS;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i) |=> (state_q == ST_DECODE))
    else $error("accepted event not decoded");

  a_status_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STATUS && sts_i.out_free) |=> (state_q == ST_IDLE))
    else $error("status word did not close the event");

  a_deliver_arrived: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_o == OP_DELIVER) |-> (sts_i.arrived_low && state_q == ST_DELIVER))
    else $error("delivery of a slot that has not arrived");

endmodule

`default_nettype wire
